### rtl/aes_pkg.sv
// ----------------------------------------------------------------------------
// aes_pkg
// shared types, constants and round functions of the aes-128 pipeline
// ----------------------------------------------------------------------------
package aes_pkg;

    localparam int unsigned BLOCK_W = 128;
    localparam int unsigned NUM_ROUNDS = 10;

    typedef logic [BLOCK_W-1:0] t_block;

    typedef enum logic {
        REQ_ENCRYPT = 1'b0,
        REQ_DECRYPT = 1'b1
    } t_req;

    typedef enum logic {
        CFG_KEY_HIGH = 1'b0,
        CFG_KEY_LOW  = 1'b1
    } t_cfg_idx;

    // one in-flight request as it moves down the rounds
    typedef struct packed {
        logic   valid;
        t_req   req;
        t_block state;
        t_block key;
    } t_stage;

    localparam logic [7:0] FWD_BOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    localparam logic [7:0] REV_BOX [256] = '{
        8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
        8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
        8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
        8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
        8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
        8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
        8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
        8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
        8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
        8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
        8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
        8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
        8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
        8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
        8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
        8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
    };

    // round constants of the key schedule, first round to last
    localparam logic [7:0] RCON [NUM_ROUNDS] = '{
        8'h01,8'h02,8'h04,8'h08,8'h10,8'h20,8'h40,8'h80,8'h1b,8'h36
    };

    // byte n of a block, byte 0 in the top bits
    function automatic logic [7:0] get_byte(input t_block b, input int unsigned n);
        return b[BLOCK_W-1-8*n -: 8];
    endfunction

    function automatic logic [7:0] xtime(input logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic t_block fwd_sub_shift(input t_block s);
        t_block t;
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                t[BLOCK_W-1-8*(c*4+r) -: 8] = FWD_BOX[get_byte(s, ((c + r) % 4) * 4 + r)];
            end
        end
        return t;
    endfunction

    function automatic t_block rev_sub_shift(input t_block s);
        t_block t;
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                t[BLOCK_W-1-8*(((c + r) % 4) * 4 + r) -: 8] = REV_BOX[get_byte(s, c * 4 + r)];
            end
        end
        return t;
    endfunction

    function automatic t_block fwd_mix(input t_block s);
        t_block t;
        logic [7:0] a0, a1, a2, a3;
        for (int c = 0; c < 4; c++) begin
            a0 = get_byte(s, c*4);
            a1 = get_byte(s, c*4+1);
            a2 = get_byte(s, c*4+2);
            a3 = get_byte(s, c*4+3);
            t[BLOCK_W-1-8*(c*4)   -: 8] = xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3;
            t[BLOCK_W-1-8*(c*4+1) -: 8] = a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3;
            t[BLOCK_W-1-8*(c*4+2) -: 8] = a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3;
            t[BLOCK_W-1-8*(c*4+3) -: 8] = xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3);
        end
        return t;
    endfunction

    // inverse mix as a pre-step on the forward mix
    function automatic t_block rev_mix(input t_block s);
        t_block t;
        logic [7:0] a0, a1, a2, a3, u, v;
        for (int c = 0; c < 4; c++) begin
            a0 = get_byte(s, c*4);
            a1 = get_byte(s, c*4+1);
            a2 = get_byte(s, c*4+2);
            a3 = get_byte(s, c*4+3);
            u = xtime(xtime(a0 ^ a2));
            v = xtime(xtime(a1 ^ a3));
            t[BLOCK_W-1-8*(c*4)   -: 8] = a0 ^ u;
            t[BLOCK_W-1-8*(c*4+1) -: 8] = a1 ^ v;
            t[BLOCK_W-1-8*(c*4+2) -: 8] = a2 ^ u;
            t[BLOCK_W-1-8*(c*4+3) -: 8] = a3 ^ v;
        end
        return fwd_mix(t);
    endfunction

    // one key schedule step forward, round constant rc
    function automatic t_block key_next(input t_block k, input logic [7:0] rc);
        logic [31:0] w0, w1, w2, w3, g;
        {w0, w1, w2, w3} = k;
        g = {FWD_BOX[w3[23:16]] ^ rc, FWD_BOX[w3[15:8]], FWD_BOX[w3[7:0]], FWD_BOX[w3[31:24]]};
        w0 = w0 ^ g;
        w1 = w1 ^ w0;
        w2 = w2 ^ w1;
        w3 = w3 ^ w2;
        return {w0, w1, w2, w3};
    endfunction

    // one key schedule step backward, rc of the key being undone
    function automatic t_block key_prev(input t_block k, input logic [7:0] rc);
        logic [31:0] w0, w1, w2, w3, g;
        {w0, w1, w2, w3} = k;
        w3 = w3 ^ w2;
        w2 = w2 ^ w1;
        w1 = w1 ^ w0;
        g = {FWD_BOX[w3[23:16]] ^ rc, FWD_BOX[w3[15:8]], FWD_BOX[w3[7:0]], FWD_BOX[w3[31:24]]};
        w0 = w0 ^ g;
        return {w0, w1, w2, w3};
    endfunction

endpackage

### rtl/aes_stream_if.sv
// ----------------------------------------------------------------------------
// aes_stream_if
// valid/ready channel carrying one payload of parameter width
// ----------------------------------------------------------------------------
interface aes_stream_if #(
    parameter int unsigned WIDTH = 129
);
    logic             valid;
    logic             ready;
    logic [WIDTH-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### rtl/aes_key_expand.sv
// ----------------------------------------------------------------------------
// aes_key_expand
// holds the cipher key, set by configuration, and its computed last round key
// ----------------------------------------------------------------------------
module aes_key_expand (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic                 i_cfg_idx,
    input  logic [63:0]          i_cfg_data,
    output aes_pkg::t_block      o_key_first,
    output aes_pkg::t_block      o_key_last,
    output logic                 o_busy
);
    import aes_pkg::*;

    // last key computed one round per cycle after each key write
    typedef logic [3:0] t_cnt;

    t_block r_key, n_key;
    t_block r_last, n_last;
    t_cnt   r_cnt, n_cnt;

    always_comb begin
        n_key  = r_key;
        n_last = r_last;
        n_cnt  = r_cnt;
        if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_KEY_HIGH: n_key[127:64] = i_cfg_data;
                CFG_KEY_LOW:  n_key[63:0]   = i_cfg_data;
                default:      n_key = r_key;
            endcase
            n_last = n_key;
            n_cnt  = '0;
        end else if (r_cnt != t_cnt'(NUM_ROUNDS)) begin
            n_last = key_next(r_last, RCON[r_cnt]);
            n_cnt  = r_cnt + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key  <= '0;
            r_last <= '0;
            r_cnt  <= '0;
        end else begin
            r_key  <= n_key;
            r_last <= n_last;
            r_cnt  <= n_cnt;
        end
    end

    assign o_key_first = r_key;
    assign o_key_last  = r_last;
    // last round key not ready yet
    assign o_busy      = (r_cnt != t_cnt'(NUM_ROUNDS));

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= t_cnt'(NUM_ROUNDS))
        else $error("key schedule counter out of range");
endmodule

### rtl/aes_round.sv
// ----------------------------------------------------------------------------
// aes_round
// one registered cipher round with its own on-the-fly round key step
// ----------------------------------------------------------------------------
module aes_round #(
    parameter int unsigned ROUND = 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  aes_pkg::t_stage   i_stage,
    output aes_pkg::t_stage   o_stage
);
    import aes_pkg::*;

    localparam bit LAST = (ROUND == NUM_ROUNDS);

    t_stage r_stage, n_stage;
    t_block enc_key, dec_key, enc_s, dec_s;

    always_comb begin
        // encrypt key walks forward, decrypt key walks backward
        enc_key = key_next(i_stage.key, RCON[ROUND-1]);
        dec_key = key_prev(i_stage.key, RCON[NUM_ROUNDS-ROUND]);
        enc_s = fwd_sub_shift(i_stage.state);
        if (!LAST) enc_s = fwd_mix(enc_s);
        enc_s = enc_s ^ enc_key;
        dec_s = rev_sub_shift(i_stage.state) ^ dec_key;
        if (!LAST) dec_s = rev_mix(dec_s);
        n_stage.valid = i_stage.valid;
        n_stage.req   = i_stage.req;
        case (i_stage.req)
            REQ_ENCRYPT: begin
                n_stage.state = enc_s;
                n_stage.key   = enc_key;
            end
            default: begin
                n_stage.state = dec_s;
                n_stage.key   = dec_key;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage.valid <= 1'b0;
        end else if (i_en) begin
            r_stage <= n_stage;
        end
    end

    assign o_stage = r_stage;
endmodule

### rtl/aes128_block_cipher_top.sv
// ----------------------------------------------------------------------------
// aes128_block_cipher_top
// pipelined aes-128 encrypt/decrypt engine, unless stalled one block per cycle
// ----------------------------------------------------------------------------
// usage
//   write key_high (index 0) and key_low (index 1) on the config port while
//   the engine is idle; the last round key is then rebuilt in the background,
//   one schedule step per cycle, and i_req.ready stays low during that time,
//   so a request always sees the new key
//   the same rebuild runs right after reset
//   i_req carries {req_type, block_high, block_low}, 0 encrypt, 1 decrypt
//   o_rsp carries {result_high, result_low}
//   a request passes through an input register with the initial key add,
//   then through ten round stages
//   throughput: one request per cycle unless stalled (receiver, key rebuild)
//   each stage derives its own round key from the one of the stage before,
//   so the key travels with the block
//   reset clears the key to zero and empties the pipeline
//   a stalled receiver freezes the whole pipeline; nothing is lost
// ----------------------------------------------------------------------------
module aes128_block_cipher_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [63:0] i_cfg_data,
    aes_stream_if.sink   i_req,
    aes_stream_if.source o_rsp
);
    import aes_pkg::*;

    t_block key_first, key_last;
    t_stage stage [NUM_ROUNDS+1];
    logic   en;
    logic   key_busy;
    t_req   in_req;
    t_block in_blk;
    t_stage r_in;

    aes_key_expand u_keys (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .o_key_first (key_first),
        .o_key_last  (key_last),
        .o_busy      (key_busy)
    );

    // whole pipeline moves when the output slot is empty or being taken
    assign en          = !stage[NUM_ROUNDS].valid || o_rsp.ready;
    // no request taken while the last round key is rebuilt
    assign i_req.ready = en && !key_busy;
    assign in_req      = t_req'(i_req.data[128]);
    assign in_blk      = i_req.data[127:0];

    // input stage: initial key add with first or last round key
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in.valid <= 1'b0;
        end else if (en) begin
            r_in.valid <= i_req.valid && !key_busy;
            r_in.req   <= in_req;
            case (in_req)
                REQ_ENCRYPT: begin
                    r_in.state <= in_blk ^ key_first;
                    r_in.key   <= key_first;
                end
                default: begin
                    r_in.state <= in_blk ^ key_last;
                    r_in.key   <= key_last;
                end
            endcase
        end
    end

    assign stage[0] = r_in;

    for (genvar g = 1; g <= NUM_ROUNDS; g++) begin : g_round
        aes_round #(.ROUND(g)) u_round (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_stage (stage[g-1]),
            .o_stage (stage[g])
        );
    end

    assign o_rsp.valid = stage[NUM_ROUNDS].valid;
    assign o_rsp.data  = stage[NUM_ROUNDS].state;

    // stalled result holds its data
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid && !o_rsp.ready |=> o_rsp.valid && $stable(o_rsp.data))
        else $error("stalled result changed");

    // an accepted request reaches the first stage
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.valid && i_req.ready |=> stage[0].valid)
        else $error("accepted request lost at input stage");

    // ready follows the output slot once the key is settled
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_rsp.valid && !key_busy |-> i_req.ready)
        else $error("pipeline stalled with empty output");
endmodule
